FILE: sv/assert_macros.svh
// Assertion macros used by the RTL of the moving average block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that expr holds at every clock edge outside reset.
`define MAD_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
// Check that cons holds in the cycle after ante.
`define MAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
// Check that cons holds in the same cycle as ante.
`define MAD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define MAD_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define MAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define MAD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/mad_pkg.sv
// Shared widths and types of the moving average block.
package mad_pkg;

  localparam int SAMPLE_W = 16;
  localparam int THR_W    = 15;

  // Divider status seen by the control sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: sv/mad_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module mad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/mad_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module mad_div #(
  parameter int DIVD_W = 20,
  parameter int DIVR_W = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVD_W-1:0]     dividend,
  input  logic [DIVR_W-1:0]     divisor,
  output logic [DIVD_W-1:0]     quotient,
  output mad_pkg::div_stat_t    stat
);

  import mad_pkg::*;

  localparam int CNT_W = (DIVD_W > 1) ? $clog2(DIVD_W) : 1;

  logic [DIVD_W-1:0] q_r, q_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIVR_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [DIVR_W:0]   rem_shl;
  logic [DIVR_W+1:0] trial;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    rem_shl = {rem_r, q_r[DIVD_W-1]};
    trial   = {1'b0, rem_shl} - {2'b00, dvs_r};
    q_nxt   = {q_r[DIVD_W-2:0], ~trial[DIVR_W+1]};
    rem_nxt = trial[DIVR_W+1] ? rem_shl[DIVR_W-1:0] : trial[DIVR_W-1:0];
  end

  // control: busy while the DIVD_W quotient bits are formed, then a one-cycle done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: sv/moving_average_deadband.sv
// Each sample passes the states IDLE, RD, DIV and FIN in that order; SUM_W = 17 + log2(WINDOW).
// A new sample is taken only in IDLE, once the last one has left FIN; in DIV the
// bit-serial divider retires one quotient bit per cycle.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) clears fill count, slot, sum, last report,
// threshold and handshake state; ring entries are read only once written.
module moving_average_deadband #(
  parameter int WINDOW = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [mad_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mad_pkg::SAMPLE_W-1:0]   out_average,
  output logic                                  out_send_flag,
  input  logic                                  cfg_wr_en,
  input  logic [mad_pkg::THR_W-1:0]             cfg_wr_data
);

  import mad_pkg::*;
`include "assert_macros.svh"

  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW) + 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic signed [SAMPLE_W-1:0] samp_r;
  logic [SLOT_W-1:0]          slot_r;
  logic [CNT_W-1:0]           fill_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic                       neg_r;
  logic signed [SAMPLE_W-1:0] last_r;
  logic [THR_W-1:0]           thr_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_avg_r;
  logic                       out_send_r;

  logic                       in_xfer, out_xfer, out_load;
  logic                       full;
  logic [SAMPLE_W-1:0]        ring_rdata;
  logic signed [SUM_W-1:0]    old_ext, new_ext, sum_nxt;
  logic [SUM_W-1:0]           mag;
  logic [CNT_W-1:0]           fill_nxt;
  logic                       div_start;
  logic [SUM_W-1:0]           quot;
  div_stat_t                  div_stat;
  logic [SUM_W-1:0]           avg_full;
  logic signed [SAMPLE_W-1:0] avg;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          adiff;
  logic                       send;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign full      = (fill_r == CNT_W'(WINDOW));
  assign div_start = (state_r == S_RD);

  // sample ring
  mad_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (div_start),
    .wr_addr (slot_r),
    .wr_data (samp_r),
    .rd_addr (slot_r),
    .rd_data (ring_rdata)
  );

  // running sum update and divider operands
  always_comb begin
    old_ext  = full ? {{(SUM_W - SAMPLE_W){ring_rdata[SAMPLE_W-1]}}, ring_rdata} : '0;
    new_ext  = {{(SUM_W - SAMPLE_W){samp_r[SAMPLE_W-1]}}, samp_r};
    sum_nxt  = sum_r - old_ext + new_ext;
    mag      = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);
    fill_nxt = full ? fill_r : fill_r + 1'b1;
  end

  mad_div #(
    .DIVD_W (SUM_W),
    .DIVR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .divisor  (fill_nxt),
    .quotient (quot),
    .stat     (div_stat)
  );

  // signed mean and deadband compare
  always_comb begin
    avg_full = neg_r ? (~quot + 1'b1) : quot;
    avg      = avg_full[SAMPLE_W-1:0];
    diff     = {avg[SAMPLE_W-1], avg} - {last_r[SAMPLE_W-1], last_r};
    adiff    = diff[SAMPLE_W] ? (SAMPLE_W + 1)'(-diff) : (SAMPLE_W + 1)'(diff);
    send     = adiff > {2'b00, thr_r};
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_RD;
      S_RD:   state_nxt = S_DIV;
      S_DIV:  if (div_stat.done) state_nxt = S_FIN;
      S_FIN:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      last_r      <= '0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (div_start) begin
        sum_r  <= sum_nxt;
        fill_r <= fill_nxt;
        slot_r <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
      end
      if (out_load && send) begin
        last_r <= avg;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      samp_r <= in_sample;
    end
    if (div_start) begin
      neg_r <= sum_nxt[SUM_W-1];
    end
    if (out_load) begin
      out_avg_r  <= avg;
      out_send_r <= send;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_average   = out_avg_r;
  assign out_send_flag = out_send_r;

  // checks
  `MAD_ASSERT_NEXT(a_accept_reads, clk, rst_n, in_xfer, state_r == S_RD)
  `MAD_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_r <= CNT_W'(WINDOW))
  `MAD_ASSERT_SAME(a_done_in_div, clk, rst_n, div_stat.done, state_r == S_DIV)
  `MAD_ASSERT_SAME(a_rise_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_FIN)
  `MAD_ASSERT_SAME(a_busy_in_div, clk, rst_n, div_stat.busy, state_r == S_DIV)

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the moving average block with deadband reporting.
`timescale 1ns / 1ps

module tb;
  import mad_pkg::*;

  localparam int WINDOW    = 8;
  localparam int HOLD_LEN  = 400;
  localparam int MAX_LINES = 40;

  typedef struct {
    logic signed [SAMPLE_W-1:0] average;
    logic                       send_flag;
  } avg_result_t;

  // DUT-facing signals; the inputs are known from time zero
  logic                       clk           = 1'b0;
  logic                       rst_n         = 1'b0;
  logic                       in_valid      = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample     = '0;
  logic                       out_valid;
  logic                       out_stall     = 1'b0;
  logic signed [SAMPLE_W-1:0] out_average;
  logic                       out_send_flag;
  logic                       cfg_wr_en     = 1'b0;
  logic [THR_W-1:0]           cfg_wr_data   = '0;

  // Predictor state
  logic signed [SAMPLE_W-1:0] held_samples [WINDOW];
  logic signed [21:0]         window_sum    = '0;
  int                         held_count    = 0;
  int                         next_slot     = 0;
  logic signed [SAMPLE_W-1:0] reported_avg  = '0;
  logic [THR_W-1:0]           threshold_q   = '0;
  avg_result_t                expected_avg_q [$];

  // Idle control and bookkeeping
  bit sender_idle_on   = 1'b1;
  bit receiver_idle_on = 1'b1;
  int stall_hold_cycles = 0;
  int drift_level      = 0;
  int items_sent       = 0;
  int results_checked  = 0;
  int flags_seen       = 0;
  int mismatch_count   = 0;

  moving_average_deadband #(.WINDOW(WINDOW)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_average  (out_average),
    .out_send_flag(out_send_flag),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // Run limit, far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Mismatch reporting
  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_LINES)
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Window mean and deadband decision for one accepted sample
  function automatic void predict_average(input logic signed [SAMPLE_W-1:0] smp);
    int          avg;
    int          avg_delta;
    avg_result_t r;
    // full ring: oldest sample drops out before the new one lands
    if (held_count >= WINDOW) window_sum -= held_samples[next_slot];
    held_samples[next_slot] = smp;
    window_sum += smp;
    if (held_count < WINDOW) held_count++;
    next_slot = (next_slot + 1) % WINDOW;
    avg  = int'(window_sum) / held_count;   // truncates toward zero
    avg_delta = avg - int'(reported_avg);
    if (avg_delta < 0) avg_delta = -avg_delta;
    r.average   = avg[SAMPLE_W-1:0];
    r.send_flag = avg_delta > int'(threshold_q);
    if (r.send_flag) reported_avg = avg[SAMPLE_W-1:0];
    expected_avg_q.push_back(r);
  endfunction

  // Offer one sample and hold it until the transfer happens
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    gap = 0;
    if (sender_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= smp;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_average(smp);
    items_sent++;
  endtask

  // Stop offering and wait until every expected average is back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_avg_q.size() == 0);
  endtask

  // Threshold write; only called with the block idle
  task automatic write_threshold(input logic [THR_W-1:0] thr);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= thr;
    @(posedge clk);
    threshold_q = thr;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mix of full-range noise, a slowly drifting level and corner values
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int kind;
    int v;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      v = $urandom_range(0, 65535) - 32768;
    end else if (kind < 8) begin
      drift_level += $urandom_range(0, 64) - 32;
      if (drift_level > 30000)  drift_level = 30000;
      if (drift_level < -30000) drift_level = -30000;
      v = drift_level + $urandom_range(0, 16) - 8;
    end else begin
      case ($urandom_range(0, 4))
        0:       v = 32767;
        1:       v = -32768;
        2:       v = -1;
        3:       v = 1;
        default: v = 0;
      endcase
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // Receiver side stall: random bursts, plus a long hold on request
  always begin
    @(negedge clk);
    if (stall_hold_cycles != 0) begin
      out_stall <= 1'b1;
      repeat (stall_hold_cycles) @(negedge clk);
      stall_hold_cycles = 0;
      out_stall <= 1'b0;
    end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 17)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  // Result checker: each transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    avg_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_avg_q.size() == 0) begin
        report_mismatch("unexpected result, average", out_average, 0);
      end else begin
        want = expected_avg_q.pop_front();
        if (out_average !== want.average)
          report_mismatch("average", out_average, want.average);
        if (out_send_flag !== want.send_flag)
          report_mismatch("send_flag", out_send_flag, want.send_flag);
        if (want.send_flag) flags_seen++;
        results_checked++;
      end
    end
  end

  // Fill-up, full window at both extremes, truncation of negative means
  task automatic test_reset_and_fill();
    write_threshold('0);
    repeat (WINDOW) send_sample(16'sh7FFF);
    repeat (WINDOW) send_sample(-16'sh8000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sd0);
    send_sample(16'sh00FF);
    wait_for_results();
  endtask

  // Deadband at the largest threshold and at the smallest nonzero one
  task automatic test_deadband_extremes();
    write_threshold({THR_W{1'b1}});
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    wait_for_results();
    write_threshold(15'd1);
    send_sample(16'sh5555);
    send_sample(-16'sh2AAB);
    wait_for_results();
  endtask

  // Random samples under a series of thresholds, draining before each write
  task automatic test_random_thresholds();
    logic [THR_W-1:0] thr;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       thr = '0;
        1:       thr = {THR_W{1'b1}};
        2:       thr = THR_W'($urandom_range(0, 63));
        3:       thr = THR_W'($urandom_range(0, 1023));
        4:       thr = THR_W'($urandom_range(0, 32767));
        5:       thr = 15'd16384;
        default: thr = THR_W'($urandom_range(0, 15));
      endcase
      // one phase runs with no idling at all
      sender_idle_on   = (phase != 3);
      receiver_idle_on = (phase != 3);
      wait_for_results();
      write_threshold(thr);
      repeat (230) send_sample(pick_sample());
    end
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    wait_for_results();
  endtask

  // Long output hold while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure();
    write_threshold(THR_W'($urandom_range(0, 255)));
    sender_idle_on    = 1'b0;
    stall_hold_cycles = HOLD_LEN;
    repeat (16) send_sample(pick_sample());
    sender_idle_on = 1'b1;
    wait_for_results();
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_full_rate();
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    write_threshold(THR_W'($urandom_range(0, 127)));
    repeat (300) send_sample(pick_sample());
    wait_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_and_fill();
    test_deadband_extremes();
    test_random_thresholds();
    test_output_backpressure();
    test_full_rate();

    // settle: nothing may arrive past the last expectation
    repeat (40) @(posedge clk);
    $display("Ran %0d samples, checked %0d averages, %0d deadband crossings",
             items_sent, results_checked, flags_seen);
    $display("Thresholds 0 to 32767, window wrap at both sample extremes, %0d-cycle output hold",
             HOLD_LEN);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/mad_pkg.sv
sv/mad_ram.sv
sv/mad_div.sv
sv/moving_average_deadband.sv
tb/sv/tb.sv
